/* design/wars_pkg.sv */
// ----------------------------------------------------------------------------
// wars_pkg
// Shared types and constants of the weighted aging ready-select table.
// ----------------------------------------------------------------------------
`default_nettype none

package wars_pkg;

  localparam int THREAD_W = 12;
  localparam int PRIO_W   = 5;
  localparam int ATT_W    = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  // The weighted product priority * (256 + attention) fits in this width.
  localparam int PROD_W   = PRIO_W + ATT_W + 1;
  // Milliseconds to seconds, applied by scaling the weight term instead.
  localparam int MS_PER_S = 1000;
  localparam int MSW_W    = 10;
  localparam int SCALED_W = PROD_W + MSW_W;
  localparam int SCORE_W  = TIME_W + ATT_W + 1;

  localparam logic REQ_INSERT   = 1'b0;
  localparam logic REQ_SCHEDULE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [THREAD_W-1:0] thread;
    logic [PRIO_W-1:0]   prio;
    logic [ATT_W-1:0]    att;
    logic [TIME_W-1:0]   ran_ms;
    logic [TIME_W-1:0]   order;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;        // write an empty entry at the sweep address
    logic rd;         // read the entry at the sweep address into the scorer
    logic scan_init;  // forget the best and free candidates
    logic load_req;   // capture the input beat
    logic commit;     // update the table and load the result register
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;  // an entry is still in flight in the scorer
    logic out_free;   // the result register can take a new beat
  } sts_t;

endpackage

`default_nettype wire

/* design/wars_if.sv */
// ----------------------------------------------------------------------------
// wars_in_if / wars_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface wars_in_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [wars_pkg::THREAD_W-1:0]      thread_id;
  logic [wars_pkg::PRIO_W-1:0]        priority_req;
  logic [wars_pkg::ATT_W-1:0]         attention;
  logic [wars_pkg::TIME_W-1:0]        last_run_ms;
  logic [wars_pkg::TIME_W-1:0]        now_ms;

  modport source (output valid, req_type, thread_id, priority_req, attention,
                  last_run_ms, now_ms, input ready);
  modport sink (input valid, req_type, thread_id, priority_req, attention,
                last_run_ms, now_ms, output ready);
endinterface

interface wars_out_if;
  logic                               valid;
  logic                               ready;
  logic [wars_pkg::STATUS_W-1:0]      status;
  logic [wars_pkg::THREAD_W-1:0]      thread_out;

  modport source (output valid, status, thread_out, input ready);
  modport sink (input valid, status, thread_out, output ready);
endinterface

`default_nettype wire

/* design/wars_ctrl.sv */
// ----------------------------------------------------------------------------
// wars_ctrl
// Sequencer: clearing sweep after reset, one slot sweep per request, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module wars_ctrl #(
  parameter int SLOTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire wars_pkg::sts_t             sts,
  output wars_pkg::cmd_t                  cmd,
  output logic [$clog2(SLOTS)-1:0]        addr
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req  = 1'b1;
          cmd.scan_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here while an earlier result has not been taken.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign addr     = cnt_r;

endmodule

`default_nettype wire

/* design/wars_dp.sv */
// ----------------------------------------------------------------------------
// wars_dp
// Slot memory, four-stage scoring pipeline, best/free trackers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wars_dp #(
  parameter int SLOTS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire wars_pkg::cmd_t                      cmd,
  output wars_pkg::sts_t                           sts,
  input  wire logic [$clog2(SLOTS)-1:0]            addr,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_wdata,
  input  wire logic                                in_req_type,
  input  wire logic [wars_pkg::THREAD_W-1:0]       in_thread_id,
  input  wire logic [wars_pkg::PRIO_W-1:0]         in_priority_req,
  input  wire logic [wars_pkg::ATT_W-1:0]          in_attention,
  input  wire logic [wars_pkg::TIME_W-1:0]         in_last_run_ms,
  input  wire logic [wars_pkg::TIME_W-1:0]         in_now_ms,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [wars_pkg::STATUS_W-1:0]            out_status,
  output logic [wars_pkg::THREAD_W-1:0]            out_thread
);

  localparam int IDX_W = $clog2(SLOTS);

  wars_pkg::entry_t mem [SLOTS];

  logic weight_en_r;
  logic [wars_pkg::TIME_W-1:0] seq_r;

  // Captured request.
  logic                            req_type_r;
  logic [wars_pkg::THREAD_W-1:0]   req_thread_r;
  logic [wars_pkg::PRIO_W-1:0]     req_prio_r;
  logic [wars_pkg::ATT_W-1:0]      req_att_r;
  logic [wars_pkg::TIME_W-1:0]     req_last_r;
  logic [wars_pkg::TIME_W-1:0]     req_now_r;

  // Stage 1: registered memory read.
  logic             p1_v_r;
  logic [IDX_W-1:0] p1_idx_r;
  wars_pkg::entry_t rd_q_r;

  // Stage 2: weight product, wait and age.
  logic                            p2_v_r, p2_live_r;
  logic [IDX_W-1:0]                p2_idx_r;
  logic [wars_pkg::THREAD_W-1:0]   p2_thread_r;
  logic [wars_pkg::PROD_W-1:0]     p2_prod_r;
  logic [wars_pkg::TIME_W-1:0]     p2_wait_r, p2_age_r;

  // Stage 3: full score.
  logic                            p3_v_r, p3_live_r;
  logic [IDX_W-1:0]                p3_idx_r;
  logic [wars_pkg::THREAD_W-1:0]   p3_thread_r;
  logic [wars_pkg::SCORE_W-1:0]    p3_score_r;
  logic [wars_pkg::TIME_W-1:0]     p3_age_r;

  // Stage 4: running best and lowest free slot.
  logic                            found_r, free_found_r;
  logic [IDX_W-1:0]                best_idx_r, free_idx_r;
  logic [wars_pkg::THREAD_W-1:0]   best_thread_r;
  logic [wars_pkg::SCORE_W-1:0]    best_score_r;
  logic [wars_pkg::TIME_W-1:0]     best_age_r;

  logic                            out_valid_r;
  logic [wars_pkg::STATUS_W-1:0]   out_status_r;
  logic [wars_pkg::THREAD_W-1:0]   out_thread_r;

  logic [wars_pkg::PROD_W-1:0]     prod_c;
  logic [wars_pkg::TIME_W-1:0]     wait_c;
  logic [wars_pkg::SCALED_W-1:0]   scaled_c;
  logic [wars_pkg::SCORE_W-1:0]    score_c;
  logic                            better_c;

  logic                            mem_we;
  logic [IDX_W-1:0]                mem_waddr;
  wars_pkg::entry_t                mem_wdata;

  // Configuration and captured request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_en_r <= 1'b1;
    end else if (cfg_we) begin
      weight_en_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r   <= in_req_type;
      req_thread_r <= in_thread_id;
      req_prio_r   <= in_priority_req;
      req_att_r    <= in_attention;
      req_last_r   <= in_last_run_ms;
      req_now_r    <= in_now_ms;
    end
  end

  // Memory: one write port, one registered read port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    priority if (cmd.clr) begin
      mem_we = 1'b1;
    end else if (cmd.commit && req_type_r == wars_pkg::REQ_INSERT && free_found_r) begin
      mem_we             = 1'b1;
      mem_waddr          = free_idx_r;
      mem_wdata.valid    = 1'b1;
      mem_wdata.thread   = req_thread_r;
      mem_wdata.prio     = req_prio_r;
      mem_wdata.att      = req_att_r;
      mem_wdata.ran_ms   = req_last_r;
      mem_wdata.order    = seq_r;
    end else if (cmd.commit && req_type_r == wars_pkg::REQ_SCHEDULE && found_r) begin
      // Removing a grant only needs the valid bit cleared.
      mem_we    = 1'b1;
      mem_waddr = best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_q_r <= mem[addr];
    end
  end

  // Stage 2 logic.
  always_comb begin
    if (weight_en_r) begin
      prod_c = wars_pkg::PROD_W'(rd_q_r.prio) *
               wars_pkg::PROD_W'({1'b1, rd_q_r.att});
    end else begin
      prod_c = wars_pkg::PROD_W'({rd_q_r.prio, {wars_pkg::ATT_W{1'b0}}});
    end
    // A thread that never ran, or whose last run lies ahead, gets no aging.
    if (rd_q_r.ran_ms != '0 && req_now_r >= rd_q_r.ran_ms) begin
      wait_c = req_now_r - rd_q_r.ran_ms;
    end else begin
      wait_c = '0;
    end
  end

  // Stage 3 logic: score in units of 1/256000, the priority weight scaled by 1000 and the wait in 1/256 ms.
  assign scaled_c = wars_pkg::SCALED_W'(p2_prod_r) *
                    wars_pkg::SCALED_W'(wars_pkg::MS_PER_S);
  assign score_c  = wars_pkg::SCORE_W'(scaled_c) +
                    wars_pkg::SCORE_W'({p2_wait_r, {wars_pkg::ATT_W{1'b0}}});

  // Stage 4 logic: equal scores go to the smaller insert age.
  assign better_c = !found_r || (p3_score_r > best_score_r) ||
                    (p3_score_r == best_score_r && p3_age_r < best_age_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.rd;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r    <= addr;
    p2_idx_r    <= p1_idx_r;
    p2_live_r   <= rd_q_r.valid;
    p2_thread_r <= rd_q_r.thread;
    p2_prod_r   <= prod_c;
    p2_wait_r   <= wait_c;
    p2_age_r    <= seq_r - rd_q_r.order;
    p3_idx_r    <= p2_idx_r;
    p3_live_r   <= p2_live_r;
    p3_thread_r <= p2_thread_r;
    p3_score_r  <= score_c;
    p3_age_r    <= p2_age_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_init) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (p3_v_r) begin
      if (p3_live_r && better_c) begin
        found_r <= 1'b1;
      end
      if (!p3_live_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p3_v_r && p3_live_r && better_c) begin
      best_idx_r    <= p3_idx_r;
      best_thread_r <= p3_thread_r;
      best_score_r  <= p3_score_r;
      best_age_r    <= p3_age_r;
    end
    // Slots arrive in ascending order, so the first free one is the lowest.
    if (p3_v_r && !p3_live_r && !free_found_r) begin
      free_idx_r <= p3_idx_r;
    end
  end

  // Insert counter and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (req_type_r == wars_pkg::REQ_INSERT && free_found_r) begin
          seq_r <= seq_r + wars_pkg::TIME_W'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      priority if (req_type_r == wars_pkg::REQ_INSERT) begin
        out_status_r <= free_found_r ? wars_pkg::STATUS_INSERTED : wars_pkg::STATUS_FULL;
        out_thread_r <= req_thread_r;
      end else if (found_r) begin
        out_status_r <= wars_pkg::STATUS_GRANTED;
        out_thread_r <= best_thread_r;
      end else begin
        out_status_r <= wars_pkg::STATUS_EMPTY;
        out_thread_r <= '0;
      end
    end
  end

  assign sts.pipe_busy = p1_v_r | p2_v_r | p3_v_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_thread = out_thread_r;

endmodule

`default_nettype wire

/* design/weighted_aging_ready_select.sv */
// ----------------------------------------------------------------------------
// weighted_aging_ready_select
// Ready table of threads with a weighted, aging highest-score pick.
// ----------------------------------------------------------------------------
// in_ch carries one request per beat: an insert (req_type 0) stores a thread in
// the lowest free slot; a schedule (req_type 1) removes and grants the valid
// slot with the highest score at time now_ms, the newest on a tie. out_ch
// returns exactly one result beat per request (status, thread_out).
// cfg_we/cfg_wdata write the weighting enable; write it only when idle.
// Every request sweeps all slots, one per cycle, into a four-stage scorer. The
// result beat is registered once the scorer has drained, and a new request is
// taken only after the previous one has committed.
// After rst_n is released, a clearing pass writes every slot empty while
// in_ch.ready is low. Weighting resets to on, the insert count to 0.
// If out_ch.ready is low, the next request is still taken and scanned, then
// waits to commit until the pending beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_aging_ready_select #(
  parameter int SLOTS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  wars_in_if.sink   in_ch,
  wars_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  wars_pkg::cmd_t cmd;
  wars_pkg::sts_t sts;
  logic [$clog2(SLOTS)-1:0] addr;

  wars_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  wars_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .addr            (addr),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_ch.req_type),
    .in_thread_id    (in_ch.thread_id),
    .in_priority_req (in_ch.priority_req),
    .in_attention    (in_ch.attention),
    .in_last_run_ms  (in_ch.last_run_ms),
    .in_now_ms       (in_ch.now_ms),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_thread      (out_ch.thread_out)
  );

  // The clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("input opened before the clearing pass");

  // One request at a time: an accepted beat closes the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input still open after an accepted beat");

  // The table is only updated once the scorer has drained.
  a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.pipe_busy && !cmd.rd)
    else $error("commit while slots still in flight");

  // An empty table reports thread zero.
  a_empty_thread: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == wars_pkg::STATUS_EMPTY |-> out_ch.thread_out == '0)
    else $error("empty result with nonzero thread");

endmodule

`default_nettype wire
